FILE: sv/idda_pkg.sv
// Shared types and constants for the isometric DDA line rasterizer.
// No dependencies; every other file of the block imports this package.
package idda_pkg;

	// Default values of the top-level parameters
	localparam int MAX_SPAN_DEF  = 64;
	localparam int GRID_BITS_DEF = 10;
	localparam int FRAC_BITS_DEF = 16;

	// Field and register widths
	localparam int COORD_W    = 10;
	localparam int HGT_W      = 10;
	localparam int SCALE_W    = 7;
	localparam int ORG_W      = 11;
	localparam int PIX_W      = 16;
	localparam int COLOR_W    = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd2;

	// Register reset values
	localparam logic [SCALE_W-1:0] SCALE_RST  = 7'd20;
	localparam logic [ORG_W-1:0]   ORIGIN_RST = 11'd250;

	// Projection constants, unsigned Q1.15: cos(0.8) and sin(0.8)
	localparam int              Q15_FRAC = 15;
	localparam logic [15:0]     COS_Q15  = 16'd22830;
	localparam logic [15:0]     SIN_Q15  = 16'd23506;

	localparam logic [COLOR_W-1:0] COLOR_RED   = 24'hff0000;
	localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hffffff;

	// Front-end arithmetic widths
	localparam int SCAL_W = COORD_W + SCALE_W;  // grid coord times scale
	localparam int SD_W   = SCAL_W + 1;         // c - r (signed) and c + r
	localparam int PROD_W = 35;                 // Q.15 projection products
	localparam int INT_W  = 20;                 // integer bits of a position, with sign

	// Sequencer wait from input capture until the step count is registered
	localparam int CALC_LAT = 7;

	typedef struct packed {
		logic load_in;
		logic div_init;
		logic div_step;
		logic run_init;
		logic emit;
		logic final_slot;
	} cmd_t;

	typedef struct packed {
		logic m_zero;
		logic more_next;
	} sts_t;

endpackage

FILE: sv/idda_ctrl.sv
// Sequencer of the isometric DDA line rasterizer: projection wait, divide, run.
// Depends on idda_pkg; drives the command struct of idda_dp.
module idda_ctrl #(
	parameter int MAX_SPAN  = idda_pkg::MAX_SPAN_DEF,
	parameter int FRAC_BITS = idda_pkg::FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  idda_pkg::sts_t  sts,
	output idda_pkg::cmd_t  cmd
);
	import idda_pkg::*;

	localparam int QUO_W   = FRAC_BITS + 2;
	localparam int TMR_MAX = (CALC_LAT > QUO_W - 1) ? CALC_LAT : QUO_W - 1;
	localparam int TMR_W   = $clog2(TMR_MAX + 1);
	localparam int CNT_W   = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CALC = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_SIGN = 3'd3;
	localparam logic [2:0] S_RUN  = 3'd4;

	logic [2:0]       state_q;
	logic [TMR_W-1:0] tmr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             emit_ok;
	logic             final_slot;
	logic             run_last;
	logic             calc_done;

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign emit_ok    = (state_q == S_RUN) && (!out_valid_q || out_ready);
	assign final_slot = (cnt_q == CNT_W'(MAX_SPAN - 1));
	assign run_last   = !sts.more_next || final_slot;
	assign calc_done  = (tmr_q == TMR_W'(CALC_LAT));

	always_comb begin
		cmd.load_in    = in_valid && in_ready;
		cmd.div_init   = (state_q == S_CALC) && calc_done && !sts.m_zero;
		cmd.div_step   = (state_q == S_DIV);
		cmd.run_init   = (state_q == S_SIGN);
		cmd.emit       = emit_ok;
		cmd.final_slot = final_slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tmr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CALC;
						tmr_q   <= '0;
					end
				end
				S_CALC: begin
					if (calc_done) begin
						state_q <= sts.m_zero ? S_IDLE : S_DIV;
						tmr_q   <= '0;
					end else begin
						tmr_q <= tmr_q + 1'b1;
					end
				end
				S_DIV: begin
					if (tmr_q == TMR_W'(QUO_W - 1)) begin
						state_q <= S_SIGN;
					end
					tmr_q <= tmr_q + 1'b1;
				end
				S_SIGN: begin
					state_q <= S_RUN;
					cnt_q   <= '0;
				end
				S_RUN: begin
					if (emit_ok) begin
						cnt_q <= cnt_q + 1'b1;
						if (run_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: sv/idda_dp.sv
// Datapath of the isometric DDA line rasterizer: projection pipe, two-lane
// restoring divider, DDA stepper and output register. Depends on idda_pkg.
module idda_dp #(
	parameter int GRID_BITS = idda_pkg::GRID_BITS_DEF,
	parameter int FRAC_BITS = idda_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  idda_pkg::cmd_t                      cmd,
	output idda_pkg::sts_t                      sts,
	input  logic [idda_pkg::SCALE_W-1:0]        scale,
	input  logic [idda_pkg::ORG_W-1:0]          origin_x,
	input  logic [idda_pkg::ORG_W-1:0]          origin_y,
	input  logic [idda_pkg::COORD_W-1:0]        col_start,
	input  logic [idda_pkg::COORD_W-1:0]        row_start,
	input  logic signed [idda_pkg::HGT_W-1:0]   height_start,
	input  logic [idda_pkg::COORD_W-1:0]        col_end,
	input  logic [idda_pkg::COORD_W-1:0]        row_end,
	input  logic signed [idda_pkg::HGT_W-1:0]   height_end,
	output logic signed [idda_pkg::PIX_W-1:0]   pix_x,
	output logic signed [idda_pkg::PIX_W-1:0]   pix_y,
	output logic [idda_pkg::COLOR_W-1:0]        color,
	output logic                                last,
	output logic                                cut
);
	import idda_pkg::*;

	localparam int POS_W  = FRAC_BITS + INT_W;
	localparam int DIFF_W = POS_W + 1;
	localparam int MAG_W  = POS_W;
	localparam int M_W    = MAG_W - FRAC_BITS;
	localparam int REM_W  = M_W + 1;
	localparam int QUO_W  = FRAC_BITS + 2;
	localparam int STEP_W = QUO_W + 1;
	localparam int CONV_W = PROD_W + 6;
	localparam int SH_UP  = (FRAC_BITS >= Q15_FRAC) ? FRAC_BITS - Q15_FRAC : 0;
	localparam int SH_DN  = (FRAC_BITS < Q15_FRAC) ? Q15_FRAC - FRAC_BITS : 0;
	localparam int ORGH_W = ORG_W + 2;

	localparam logic [COORD_W-1:0] GRID_MASK = COORD_W'((1 << GRID_BITS) - 1);
	localparam logic signed [PROD_W-1:0] COS_S = PROD_W'(COS_Q15);
	localparam logic [PROD_W-1:0]        SIN_U = PROD_W'(SIN_Q15);
	localparam logic signed [CONV_W-1:0] DN_BIAS = CONV_W'((1 << SH_DN) - 1);
	localparam logic signed [DIFF_W-1:0] ONE_D =
		{{(DIFF_W - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
	localparam logic signed [DIFF_W-1:0] NEG_ONE_D = -ONE_D;
	localparam logic signed [POS_W-1:0]  FRAC_MASK =
		{{(POS_W - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

	// Q.15 product to a position with FRAC_BITS fraction bits, toward zero
	function automatic logic signed [POS_W-1:0] q15_conv(input logic signed [PROD_W-1:0] p);
		logic signed [CONV_W-1:0] w;
		logic signed [CONV_W-1:0] b;
		logic signed [CONV_W-1:0] r;
		w = {{(CONV_W - PROD_W){p[PROD_W-1]}}, p};
		b = w[CONV_W-1] ? DN_BIAS : '0;
		r = ((w + b) >>> SH_DN) <<< SH_UP;
		return r[POS_W-1:0];
	endfunction

	function automatic logic int_nonzero(input logic signed [DIFF_W-1:0] v);
		return (v >= ONE_D) || (v <= NEG_ONE_D);
	endfunction

	function automatic logic [PIX_W-1:0] pix_of(input logic signed [POS_W-1:0] v);
		logic signed [POS_W-1:0] a;
		a = v + (v[POS_W-1] ? FRAC_MASK : '0);
		return a[FRAC_BITS+PIX_W-1:FRAC_BITS];
	endfunction

	// captured edge
	logic [COORD_W-1:0]       col0_q, row0_q, col1_q, row1_q;
	logic signed [HGT_W-1:0]  h0_q, h1_q;
	logic [COLOR_W-1:0]       color_q;

	// projection pipe
	logic [SCAL_W-1:0]        c0_s1, r0_s1, c1_s1, r1_s1;
	logic signed [SD_W-1:0]   d0_s2, d1_s2;
	logic [SD_W-1:0]          a0_s2, a1_s2;
	logic signed [PROD_W-1:0] px0_s3, py0_s3, px1_s3, py1_s3;
	logic signed [POS_W-1:0]  x0_s4, y0_s4, x1_s4, y1_s4;
	logic signed [DIFF_W-1:0] dx_s5, dy_s5;
	logic [MAG_W-1:0]         adx_s6, ady_s6;
	logic [M_W-1:0]           m_s7;

	// divider lanes
	logic [REM_W-1:0]         rem_x_q, rem_y_q;
	logic [QUO_W-1:0]         quo_x_q, quo_y_q;
	logic [REM_W-1:0]         trial_x, trial_y;
	logic                     ge_x, ge_y;

	// stepper
	logic signed [STEP_W-1:0] sx_q, sy_q;
	logic signed [POS_W-1:0]  x_q, y_q;
	logic signed [DIFF_W-1:0] ex_q, ey_q;
	logic signed [DIFF_W-1:0] ex_nxt, ey_nxt;
	logic                     more_next;

	logic signed [ORGH_W-1:0] oyh0, oyh1;
	logic signed [POS_W-1:0]  ox_pos;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			col0_q  <= col_start & GRID_MASK;
			row0_q  <= row_start & GRID_MASK;
			col1_q  <= col_end & GRID_MASK;
			row1_q  <= row_end & GRID_MASK;
			h0_q    <= height_start;
			h1_q    <= height_end;
			color_q <= (height_start != '0 || height_end != '0) ? COLOR_RED : COLOR_WHITE;
		end
	end

	// Free-running pipe; the captured edge is held until the run is over.
	assign oyh0   = $signed({2'b00, origin_y}) - ORGH_W'(h0_q);
	assign oyh1   = $signed({2'b00, origin_y}) - ORGH_W'(h1_q);
	assign ox_pos = $signed({{(POS_W - ORG_W){1'b0}}, origin_x}) <<< FRAC_BITS;

	always_ff @(posedge clk) begin
		c0_s1  <= SCAL_W'(col0_q) * SCAL_W'(scale);
		r0_s1  <= SCAL_W'(row0_q) * SCAL_W'(scale);
		c1_s1  <= SCAL_W'(col1_q) * SCAL_W'(scale);
		r1_s1  <= SCAL_W'(row1_q) * SCAL_W'(scale);

		d0_s2  <= $signed({1'b0, c0_s1}) - $signed({1'b0, r0_s1});
		d1_s2  <= $signed({1'b0, c1_s1}) - $signed({1'b0, r1_s1});
		a0_s2  <= {1'b0, c0_s1} + {1'b0, r0_s1};
		a1_s2  <= {1'b0, c1_s1} + {1'b0, r1_s1};

		px0_s3 <= PROD_W'(d0_s2 * COS_S);
		px1_s3 <= PROD_W'(d1_s2 * COS_S);
		py0_s3 <= $signed(PROD_W'(a0_s2 * SIN_U));
		py1_s3 <= $signed(PROD_W'(a1_s2 * SIN_U));

		x0_s4  <= q15_conv(px0_s3) + ox_pos;
		x1_s4  <= q15_conv(px1_s3) + ox_pos;
		y0_s4  <= q15_conv(py0_s3) + (POS_W'(oyh0) <<< FRAC_BITS);
		y1_s4  <= q15_conv(py1_s3) + (POS_W'(oyh1) <<< FRAC_BITS);

		dx_s5  <= DIFF_W'(x1_s4) - DIFF_W'(x0_s4);
		dy_s5  <= DIFF_W'(y1_s4) - DIFF_W'(y0_s4);

		adx_s6 <= MAG_W'(dx_s5[DIFF_W-1] ? -dx_s5 : dx_s5);
		ady_s6 <= MAG_W'(dy_s5[DIFF_W-1] ? -dy_s5 : dy_s5);

		m_s7   <= (adx_s6 > ady_s6) ? adx_s6[MAG_W-1:FRAC_BITS] : ady_s6[MAG_W-1:FRAC_BITS];
	end

	// One quotient bit per cycle on both lanes; remainder stays below m.
	assign trial_x = {rem_x_q[REM_W-2:0], quo_x_q[QUO_W-1]};
	assign trial_y = {rem_y_q[REM_W-2:0], quo_y_q[QUO_W-1]};
	assign ge_x    = (trial_x >= {1'b0, m_s7});
	assign ge_y    = (trial_y >= {1'b0, m_s7});

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_x_q <= REM_W'(adx_s6[MAG_W-1:QUO_W]);
			rem_y_q <= REM_W'(ady_s6[MAG_W-1:QUO_W]);
			quo_x_q <= adx_s6[QUO_W-1:0];
			quo_y_q <= ady_s6[QUO_W-1:0];
		end else if (cmd.div_step) begin
			rem_x_q <= ge_x ? trial_x - {1'b0, m_s7} : trial_x;
			rem_y_q <= ge_y ? trial_y - {1'b0, m_s7} : trial_y;
			quo_x_q <= {quo_x_q[QUO_W-2:0], ge_x};
			quo_y_q <= {quo_y_q[QUO_W-2:0], ge_y};
		end
	end

	assign ex_nxt    = ex_q + {{(DIFF_W - STEP_W){sx_q[STEP_W-1]}}, sx_q};
	assign ey_nxt    = ey_q + {{(DIFF_W - STEP_W){sy_q[STEP_W-1]}}, sy_q};
	assign more_next = int_nonzero(ex_nxt) || int_nonzero(ey_nxt);

	always_ff @(posedge clk) begin
		if (cmd.run_init) begin
			sx_q <= dx_s5[DIFF_W-1] ? -$signed({1'b0, quo_x_q}) : $signed({1'b0, quo_x_q});
			sy_q <= dy_s5[DIFF_W-1] ? -$signed({1'b0, quo_y_q}) : $signed({1'b0, quo_y_q});
			x_q  <= x0_s4;
			y_q  <= y0_s4;
			ex_q <= -dx_s5;
			ey_q <= -dy_s5;
		end else if (cmd.emit) begin
			x_q  <= x_q + {{(POS_W - STEP_W){sx_q[STEP_W-1]}}, sx_q};
			y_q  <= y_q + {{(POS_W - STEP_W){sy_q[STEP_W-1]}}, sy_q};
			ex_q <= ex_nxt;
			ey_q <= ey_nxt;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pix_x <= $signed(pix_of(x_q));
			pix_y <= $signed(pix_of(y_q));
			color <= color_q;
			last  <= !more_next || cmd.final_slot;
			cut   <= more_next && cmd.final_slot;
		end
	end

	always_comb begin
		sts.m_zero    = (m_s7 == '0);
		sts.more_next = more_next;
	end

endmodule

FILE: sv/isometric_dda_line_raster.sv
// Top level of the isometric DDA line rasterizer: configuration registers,
// sequencer (idda_ctrl) and datapath (idda_dp). Depends on idda_pkg.
//
//   channel | signals                          | moves
//   --------+----------------------------------+---------------------------------
//   in      | in_valid / in_ready              | one edge request: two grid points
//   out     | out_valid / out_ready            | one pixel per request beat
//   cfg     | cfg_we, cfg_idx, cfg_data        | register write, no wait, no read
//
// An edge passes input capture, the projection pipe and step-count logic,
// the shared two-lane restoring divider (one quotient bit per cycle), a
// step-sign state, then the stepper, which emits up to MAX_SPAN pixels.
// A degenerate edge (zero step count) returns to idle after the projection
// wait, with no divide and no pixels.
// in_ready is high only while no edge is in work; the last pixel of an edge
// may still sit in the output register while the next edge is taken.
// A stall on out_ready holds the stepper; reset clears control and config registers only.
module isometric_dda_line_raster #(
	parameter int MAX_SPAN  = idda_pkg::MAX_SPAN_DEF,
	parameter int GRID_BITS = idda_pkg::GRID_BITS_DEF,
	parameter int FRAC_BITS = idda_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [idda_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [idda_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [idda_pkg::COORD_W-1:0]        col_start,
	input  logic [idda_pkg::COORD_W-1:0]        row_start,
	input  logic signed [idda_pkg::HGT_W-1:0]   height_start,
	input  logic [idda_pkg::COORD_W-1:0]        col_end,
	input  logic [idda_pkg::COORD_W-1:0]        row_end,
	input  logic signed [idda_pkg::HGT_W-1:0]   height_end,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [idda_pkg::PIX_W-1:0]   pix_x,
	output logic signed [idda_pkg::PIX_W-1:0]   pix_y,
	output logic [idda_pkg::COLOR_W-1:0]        color,
	output logic                                last,
	output logic                                cut
);
	import idda_pkg::*;

	logic [SCALE_W-1:0] scale_q;
	logic [ORG_W-1:0]   origin_x_q;
	logic [ORG_W-1:0]   origin_y_q;
	cmd_t               cmd;
	sts_t               sts;

	// Writes to an index past the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q    <= SCALE_RST;
			origin_x_q <= ORIGIN_RST;
			origin_y_q <= ORIGIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SCALE:    scale_q    <= cfg_data[SCALE_W-1:0];
				REG_ORIGIN_X: origin_x_q <= cfg_data[ORG_W-1:0];
				REG_ORIGIN_Y: origin_y_q <= cfg_data[ORG_W-1:0];
				default: ;
			endcase
		end
	end

	idda_ctrl #(
		.MAX_SPAN  (MAX_SPAN),
		.FRAC_BITS (FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	idda_dp #(
		.GRID_BITS (GRID_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.sts          (sts),
		.scale        (scale_q),
		.origin_x     (origin_x_q),
		.origin_y     (origin_y_q),
		.col_start    (col_start),
		.row_start    (row_start),
		.height_start (height_start),
		.col_end      (col_end),
		.row_end      (row_end),
		.height_end   (height_end),
		.pix_x        (pix_x),
		.pix_y        (pix_y),
		.color        (color),
		.last         (last),
		.cut          (cut)
	);

endmodule

FILE: dv/idda_pixel_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the isometric DDA line rasterizer: predicts the pixel run of
// every accepted edge request and compares it with each accepted pixel beat.
// Depends on idda_pkg; sits beside the block in tb_isometric_dda_line_raster.
module idda_pixel_checker #(
	parameter int MAX_SPAN  = idda_pkg::MAX_SPAN_DEF,
	parameter int GRID_BITS = idda_pkg::GRID_BITS_DEF,
	parameter int FRAC_BITS = idda_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [idda_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [idda_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic [idda_pkg::COORD_W-1:0]        col_start,
	input  logic [idda_pkg::COORD_W-1:0]        row_start,
	input  logic signed [idda_pkg::HGT_W-1:0]   height_start,
	input  logic [idda_pkg::COORD_W-1:0]        col_end,
	input  logic [idda_pkg::COORD_W-1:0]        row_end,
	input  logic signed [idda_pkg::HGT_W-1:0]   height_end,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic signed [idda_pkg::PIX_W-1:0]   pix_x,
	input  logic signed [idda_pkg::PIX_W-1:0]   pix_y,
	input  logic [idda_pkg::COLOR_W-1:0]        color,
	input  logic                                last,
	input  logic                                cut,
	output int                                  errors,
	output int                                  pending
);
	import idda_pkg::*;

	typedef struct packed {
		logic [PIX_W-1:0]   x;
		logic [PIX_W-1:0]   y;
		logic [COLOR_W-1:0] color;
		logic               last;
		logic               cut;
	} pixel_t;

	localparam logic [COORD_W-1:0] GRID_MASK = COORD_W'((longint'(1) << GRID_BITS) - 1);
	localparam longint ONE = longint'(1) << FRAC_BITS;

	// shadow of the register file
	logic [SCALE_W-1:0] scale_q = SCALE_RST;
	logic [ORG_W-1:0]   org_x_q = ORIGIN_RST;
	logic [ORG_W-1:0]   org_y_q = ORIGIN_RST;

	pixel_t expected_pixels[$];
	int     fail_cnt = 0;
	int     queued   = 0;

	assign errors  = fail_cnt;
	assign pending = queued;

	// truncation toward zero, as the stepper does
	function automatic longint whole_part(longint v);
		return v / ONE;
	endfunction

	// Q.15 product to position format
	function automatic longint q15_to_frac(longint p);
		if (FRAC_BITS >= Q15_FRAC) begin
			return p * (longint'(1) << (FRAC_BITS - Q15_FRAC));
		end
		return p / (longint'(1) << (Q15_FRAC - FRAC_BITS));
	endfunction

	function automatic bit not_arrived(longint x, longint y, longint x1, longint y1);
		return whole_part(x - x1) != 0 || whole_part(y - y1) != 0;
	endfunction

	task automatic project_point(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
			input logic signed [HGT_W-1:0] hgt, output longint px, output longint py);
		longint c, r;
		c  = longint'(col & GRID_MASK) * longint'(scale_q);
		r  = longint'(row & GRID_MASK) * longint'(scale_q);
		px = q15_to_frac((c - r) * longint'(COS_Q15)) + longint'(org_x_q) * ONE;
		py = q15_to_frac((c + r) * longint'(SIN_Q15)) - longint'(hgt) * ONE
			+ longint'(org_y_q) * ONE;
	endtask

	task automatic rasterize_edge(input logic [COORD_W-1:0] c0, input logic [COORD_W-1:0] r0,
			input logic signed [HGT_W-1:0] h0, input logic [COORD_W-1:0] c1,
			input logic [COORD_W-1:0] r1, input logic signed [HGT_W-1:0] h1);
		longint x, y, x1, y1, dx, dy, adx, ady, m, sx, sy, px, py;
		logic [COLOR_W-1:0] hue;
		pixel_t pix;
		int n;
		hue = (h0 != 0 || h1 != 0) ? COLOR_RED : COLOR_WHITE;
		project_point(c0, r0, h0, x, y);
		project_point(c1, r1, h1, x1, y1);
		dx  = x1 - x;
		dy  = y1 - y;
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		m   = whole_part(adx > ady ? adx : ady);
		if (m == 0) begin
			return;
		end
		sx = dx / m;
		sy = dy / m;
		n  = 0;
		while (n < MAX_SPAN && not_arrived(x, y, x1, y1)) begin
			px        = whole_part(x);
			py        = whole_part(y);
			pix.x     = px[PIX_W-1:0];
			pix.y     = py[PIX_W-1:0];
			pix.color = hue;
			pix.last  = 1'b0;
			pix.cut   = 1'b0;
			expected_pixels.push_back(pix);
			x += sx;
			y += sy;
			n++;
		end
		if (n > 0) begin
			pix      = expected_pixels.pop_back();
			pix.last = 1'b1;
			pix.cut  = (n == MAX_SPAN) && not_arrived(x, y, x1, y1);
			expected_pixels.push_back(pix);
		end
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t ns pixel check: %s got %0d want %0d", $time, what, got, want);
		fail_cnt++;
	endtask

	task automatic check_pixel();
		pixel_t want;
		if (expected_pixels.size() == 0) begin
			report_mismatch("pixel with no edge pending, pix_x", pix_x, 0);
			return;
		end
		want = expected_pixels.pop_front();
		if (pix_x !== want.x)
			report_mismatch("pix_x", pix_x, $signed(want.x));
		if (pix_y !== want.y)
			report_mismatch("pix_y", pix_y, $signed(want.y));
		if (color !== want.color)
			report_mismatch("color", color, want.color);
		if (last !== want.last)
			report_mismatch("last", last, want.last);
		if (cut !== want.cut)
			report_mismatch("cut", cut, want.cut);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q = SCALE_RST;
			org_x_q = ORIGIN_RST;
			org_y_q = ORIGIN_RST;
			expected_pixels.delete();
			queued = 0;
		end else begin
			if (out_valid && out_ready)
				check_pixel();
			if (in_valid && in_ready)
				rasterize_edge(col_start, row_start, height_start, col_end, row_end, height_end);
			if (cfg_we) begin
				case (cfg_idx)
					REG_SCALE:    scale_q = cfg_data[SCALE_W-1:0];
					REG_ORIGIN_X: org_x_q = cfg_data[ORG_W-1:0];
					REG_ORIGIN_Y: org_y_q = cfg_data[ORG_W-1:0];
					default: ;
				endcase
			end
			queued = expected_pixels.size();
		end
	end

endmodule

FILE: dv/tb_isometric_dda_line_raster.sv
`timescale 1ns / 100ps
// Testbench top for the isometric DDA line rasterizer: clock, reset, edge
// requests, register writes, receiver stalls and verdict. Depends on idda_pkg,
// the block and idda_pixel_checker, which does all prediction and comparison.
module tb_isometric_dda_line_raster;
	import idda_pkg::*;

	// index past the register list; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam int QUIET_LIMIT = 5000;  // cycles with no handshake at all
	localparam int HOLD_OFF    = 400;   // long receiver back-pressure
	localparam int SETTLE      = 40;    // > degenerate-edge turnaround and front-end latency
	localparam int PHASE_EDGES = 42;
	localparam int N_PHASES    = 6;

	// receiver stall patterns
	typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_mode_t;

	// shapes of random edges
	typedef enum int {EDGE_WILD, EDGE_NEAR, EDGE_FLAT, EDGE_RISER, EDGE_DOT} edge_kind_t;

	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_idx      = '0;
	logic [CFG_DATA_W-1:0]   cfg_data     = '0;
	logic                    in_valid     = 1'b0;
	logic                    in_ready;
	logic [COORD_W-1:0]      col_start    = '0;
	logic [COORD_W-1:0]      row_start    = '0;
	logic signed [HGT_W-1:0] height_start = '0;
	logic [COORD_W-1:0]      col_end      = '0;
	logic [COORD_W-1:0]      row_end      = '0;
	logic signed [HGT_W-1:0] height_end   = '0;
	logic                    out_valid;
	logic                    out_ready    = 1'b0;
	logic signed [PIX_W-1:0] pix_x;
	logic signed [PIX_W-1:0] pix_y;
	logic [COLOR_W-1:0]      color;
	logic                    last;
	logic                    cut;

	int errors;
	int pending;

	int burst_left = 0;   // requests left in the current sender burst
	bit hold_req   = 1'b0; // asks the receiver for one long hold-off
	int quiet      = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	isometric_dda_line_raster dut (.*);

	idda_pixel_checker pixel_check (.*);

	// Watchdog: any stretch this long without a single handshake means the
	// block hung or lost a pixel; the longest legal quiet stretch is the
	// receiver hold-off plus an edge's front-end latency.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	// Receiver: picks one of its stall patterns, one of which never stalls, for
	// a span of random length. A hold request from the stimulus side parks
	// out_ready low for the HOLD_OFF span so the stepper backs up into in_ready.
	initial begin
		rx_mode_t mode;
		int span;
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			span = $urandom_range(30, 200);
			repeat (span) begin
				@(negedge clk);
				if (hold_req) begin
					hold_req = 1'b0;
					out_ready <= 1'b0;
					repeat (HOLD_OFF) @(negedge clk);
				end else begin
					case (mode)
						RX_OPEN:   out_ready <= 1'b1;
						RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
						RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
						default:   out_ready <= ~out_ready;
					endcase
				end
			end
		end
	end

	// One edge request. Called at a falling edge; returns at the falling edge
	// after acceptance with in_valid still high, so the next call either
	// replaces the payload in place or opens a gap.
	task automatic send_edge(input logic [COORD_W-1:0] c0, input logic [COORD_W-1:0] r0,
			input logic signed [HGT_W-1:0] h0, input logic [COORD_W-1:0] c1,
			input logic [COORD_W-1:0] r1, input logic signed [HGT_W-1:0] h1);
		int gap;
		if (burst_left == 0) begin
			// long bursts give stretches with no sender idling
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		burst_left--;
		col_start    <= c0;
		row_start    <= r0;
		height_start <= h0;
		col_end      <= c1;
		row_end      <= r1;
		height_end   <= h1;
		in_valid     <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Random edge. Most are short edges (a few grid steps, or a pure height change
	// of up to 70 that may pass the span cap); the rest are wild edges that hit the
	// span cap, plus degenerate ones that emit nothing.
	task automatic random_edge();
		logic [COORD_W-1:0] c0, r0, c1, r1;
		logic signed [HGT_W-1:0] h0, h1;
		edge_kind_t kind;
		int pick;
		pick = $urandom_range(0, 9);
		kind = pick < 3 ? EDGE_WILD : pick < 6 ? EDGE_NEAR : pick < 7 ? EDGE_FLAT
			: pick < 9 ? EDGE_RISER : EDGE_DOT;
		c0 = COORD_W'($urandom);
		r0 = COORD_W'($urandom);
		h0 = HGT_W'($urandom);
		c1 = COORD_W'($urandom);
		r1 = COORD_W'($urandom);
		h1 = HGT_W'($urandom);
		case (kind)
			EDGE_NEAR, EDGE_FLAT: begin
				c1 = c0 + COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
				r1 = r0 + COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
				h1 = h0 + HGT_W'($urandom_range(0, 8)) - HGT_W'(4);
				if (kind == EDGE_FLAT) begin
					h0 = '0;
					h1 = '0;
				end
			end
			EDGE_RISER: begin
				// vertical run of |h1-h0| pixels up to MAX_SPAN, around the cap
				c1 = c0;
				r1 = r0;
				h1 = h0 + HGT_W'($urandom_range(0, 140)) - HGT_W'(70);
			end
			EDGE_DOT: begin
				c1 = c0;
				r1 = r0;
				h1 = h0;
			end
			default: ;
		endcase
		send_edge(c0, r0, h0, c1, r1, h1);
	endtask

	// Register writes only happen with the block idle. Bits above the scale
	// field carry noise since the block must ignore them; the last write goes
	// to the unused index and must change nothing.
	task automatic program_regs(input logic [SCALE_W-1:0] s, input logic [ORG_W-1:0] ox,
			input logic [ORG_W-1:0] oy);
		cfg_we   <= 1'b1;
		cfg_idx  <= REG_SCALE;
		cfg_data <= {(CFG_DATA_W - SCALE_W)'($urandom), s};
		@(negedge clk);
		cfg_idx  <= REG_ORIGIN_X;
		cfg_data <= ox;
		@(negedge clk);
		cfg_idx  <= REG_ORIGIN_Y;
		cfg_data <= oy;
		@(negedge clk);
		cfg_idx  <= REG_UNUSED;
		cfg_data <= CFG_DATA_W'($urandom);
		@(negedge clk);
		cfg_we   <= 1'b0;
	endtask

	// Stop offering, wait for every predicted pixel, then let a trailing
	// degenerate edge finish before anything else happens.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed edges at the reset register values (scale 20, origin 250)
		send_edge(10'd5, 10'd5, 10'sd0, 10'd5, 10'd5, 10'sd0);         // degenerate: no pixels
		send_edge(10'd0, 10'd0, 10'sd0, 10'd1023, 10'd1023, 10'sd0);   // grid corners, capped
		send_edge(10'd1023, 10'd0, -10'sd512, 10'd0, 10'd1023, 10'sd511);
		send_edge(10'd0, 10'd1023, 10'sd511, 10'd1023, 10'd0, -10'sd512);
		send_edge(10'd7, 10'd7, -10'sd512, 10'd7, 10'd7, 10'sd511);    // full height swing
		send_edge(10'd5, 10'd5, 10'sd0, 10'd6, 10'd5, 10'sd0);         // one column, white
		send_edge(10'd5, 10'd5, 10'sd0, 10'd5, 10'd6, 10'sd0);         // one row, white
		send_edge(10'd5, 10'd5, 10'sd3, 10'd5, 10'd5, 10'sd4);         // single pixel
		send_edge(10'd5, 10'd5, 10'sd0, 10'd5, 10'd5, 10'sd64);        // exactly the cap, not cut
		send_edge(10'd5, 10'd5, 10'sd0, 10'd5, 10'd5, 10'sd65);        // one past the cap, cut
		send_edge(10'd5, 10'd5, 10'sd0, 10'd5, 10'd5, 10'sd63);
		send_edge(10'd100, 10'd200, 10'sd0, 10'd101, 10'd200, -10'sd1); // red from end height
		send_edge(10'd100, 10'd200, 10'sd1, 10'd100, 10'd201, 10'sd0);  // red from start height
		send_edge(10'd512, 10'd0, 10'sd0, 10'd512, 10'd1, 10'sd0);
		send_edge(10'd0, 10'd0, 10'sd0, 10'd0, 10'd0, -10'sd1);
		send_edge(10'd1023, 10'd1023, -10'sd1, 10'd1023, 10'd1023, 10'sd0);
		send_edge(10'd341, 10'd682, 10'sd0, 10'd342, 10'd681, 10'sd0);
		repeat (PHASE_EDGES) random_edge();
		drain();

		// Register sweeps: minimum scale at the screen corner, maximum legal
		// scale at the far corner, out-of-range scales (large enough to wrap
		// the pixel coordinates, and zero), then random settings.
		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0:       program_regs(7'd1, 11'd0, 11'd0);
				1:       program_regs(7'd64, 11'd2047, 11'd2047);
				2:       program_regs(7'd127, 11'd0, 11'd2047);
				3:       program_regs(7'd0, 11'd1024, 11'd3);
				default: program_regs(SCALE_W'($urandom_range(1, 64)),
						ORG_W'($urandom_range(0, 2047)), ORG_W'($urandom_range(0, 2047)));
			endcase
			// long back-pressure while the sender keeps offering
			if (p == 1)
				hold_req = 1'b1;
			repeat (PHASE_EDGES) random_edge();
			drain();
		end

		if (errors == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/idda_pkg.sv
sv/idda_ctrl.sv
sv/idda_dp.sv
sv/isometric_dda_line_raster.sv
dv/idda_pixel_checker.sv
dv/tb_isometric_dda_line_raster.sv
